### design/hill_cipher_3x3_mod26_top_assert.svh
// Assertion macros shared by the Hill cipher RTL files.
`ifndef HILL_CIPHER_3X3_MOD26_TOP_ASSERT_SVH
`define HILL_CIPHER_3X3_MOD26_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/hc_pkg.sv
// Shared types, constants and mod-26 helpers for the Hill cipher block.
package hc_pkg;

    localparam int unsigned LETTER_W = 5;
    localparam int unsigned KEY_W    = 15;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned PROD_W   = 10;

    localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;
    // Multiple of 26 that is at least the largest product, so a subtraction stays positive.
    localparam logic [PROD_W-1:0]   SUB_BIAS   = 10'd650;

    localparam logic [CFG_AW-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_KEY0 = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_KEY1 = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_KEY2 = 2'd3;

    typedef struct packed {
        logic                vld;
        logic                first;
        logic                last;
        logic                sub;
        logic [LETTER_W-1:0] a;
        logic [LETTER_W-1:0] b;
    } t_mac_op;

    typedef struct packed {
        logic                vld;
        logic [LETTER_W-1:0] value;
    } t_mac_res;

    typedef struct packed {
        logic [3:0] ia;
        logic [3:0] ib;
    } t_kpair;

    function automatic logic [LETTER_W-1:0] red26_5(input logic [LETTER_W-1:0] x);
        return (x >= MODULUS) ? x - MODULUS : x;
    endfunction

    // Reduces values below 676: reciprocal estimate, then one correction step.
    function automatic logic [LETTER_W-1:0] mod26_10(input logic [PROD_W-1:0] x);
        logic [18:0]       m;
        logic [5:0]        q;
        logic [PROD_W-1:0] r;
        m = {9'd0, x} * 19'd315;
        q = m[18:13];
        r = x - ({4'd0, q} * 10'd26);
        if (r >= {5'd0, MODULUS}) begin
            r = r - {5'd0, MODULUS};
        end
        return r[LETTER_W-1:0];
    endfunction

    // Key entry indices of the two products of each adjugate entry, two steps per entry.
    function automatic t_kpair adj_term(input logic [4:0] step);
        t_kpair p;
        unique case (step)
            5'd0:    p = '{ia: 4'd4, ib: 4'd8};
            5'd1:    p = '{ia: 4'd5, ib: 4'd7};
            5'd2:    p = '{ia: 4'd2, ib: 4'd7};
            5'd3:    p = '{ia: 4'd1, ib: 4'd8};
            5'd4:    p = '{ia: 4'd1, ib: 4'd5};
            5'd5:    p = '{ia: 4'd2, ib: 4'd4};
            5'd6:    p = '{ia: 4'd5, ib: 4'd6};
            5'd7:    p = '{ia: 4'd3, ib: 4'd8};
            5'd8:    p = '{ia: 4'd0, ib: 4'd8};
            5'd9:    p = '{ia: 4'd2, ib: 4'd6};
            5'd10:   p = '{ia: 4'd2, ib: 4'd3};
            5'd11:   p = '{ia: 4'd0, ib: 4'd5};
            5'd12:   p = '{ia: 4'd3, ib: 4'd7};
            5'd13:   p = '{ia: 4'd4, ib: 4'd6};
            5'd14:   p = '{ia: 4'd1, ib: 4'd6};
            5'd15:   p = '{ia: 4'd0, ib: 4'd7};
            5'd16:   p = '{ia: 4'd0, ib: 4'd4};
            5'd17:   p = '{ia: 4'd1, ib: 4'd3};
            default: p = '{ia: 4'd0, ib: 4'd0};
        endcase
        return p;
    endfunction

    // Multiplicative inverse mod 26; zero where none exists.
    function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] d);
        logic [LETTER_W-1:0] r;
        unique case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

### design/hill_cipher_3x3_mod26_top.sv
// Top level of the 3x3 Hill cipher block (mod 26) with stream ports and a config write port.
// Letters are taken one word per cycle until a group of three is complete (or the
// message ends, padding with 'x'); the group then runs through a single 5x5-bit
// multiply-accumulate unit, nine products back to back, and the three result words
// leave through a three-entry output buffer while the next letters are accepted.
// When the output side keeps up, a group takes its three letter words, a pass through the start
// state and nine products; the pace is set by the one shared multiplier.
// A full group waits in the start state, with the input stalled, until the previous
// group's three words have left. The first decrypted group after reset or after any
// config write first builds the inverse key on the same unit: 18 adjugate products,
// 3 for the determinant, 9 scalings and two pipeline drains.
`include "hill_cipher_3x3_mod26_top_assert.svh"

module hill_cipher_3x3_mod26_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input stream. tdata: [4:0] letter_in, [7:5] zero. tlast: message_end.
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,
    input  logic                        i_s_axis_tlast,
    // Output stream. tdata: [4:0] letter_out, [7:5] zero. tlast: group_last.
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [7:0]                  o_m_axis_tdata,
    output logic                        o_m_axis_tlast,
    // tuser: [0] key_error.
    output logic                        o_m_axis_tuser,
    // Configuration writes.
    input  logic                        i_cfg_we,
    input  logic [hc_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [hc_pkg::KEY_W-1:0]    i_cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_ADJ   = 3'd2;
    localparam logic [2:0] ST_DET   = 3'd3;
    localparam logic [2:0] ST_WDET  = 3'd4;
    localparam logic [2:0] ST_INV   = 3'd5;
    localparam logic [2:0] ST_COL   = 3'd6;

    localparam logic [4:0] ADJ_LAST = 5'd17;
    localparam logic [4:0] DET_LAST = 5'd2;
    localparam logic [4:0] INV_LAST = 5'd8;
    localparam logic [4:0] ADJ_N    = 5'd9;
    localparam logic [4:0] DET_IDX  = 5'd9;
    localparam logic [4:0] INV_BASE = 5'd10;
    localparam logic [1:0] LAST_IX  = 2'd2;

    localparam int unsigned LW = hc_pkg::LETTER_W;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [4:0]           r_step;
    logic [1:0]           r_row;
    logic [1:0]           r_col;

    logic                 r_mode;
    logic [hc_pkg::KEY_W-1:0] r_key [3];

    logic [LW-1:0]        r_hold [2];
    logic [1:0]           r_hcnt;
    logic [LW-1:0]        r_v [3];

    logic [LW-1:0]        r_adj [9];
    logic [LW-1:0]        r_inv [9];
    logic [LW-1:0]        r_det;
    logic                 r_inv_ready;
    logic                 r_key_ok;

    logic                 r_build;
    logic [4:0]           r_wr_idx;

    logic [LW-1:0]        r_obuf [3];
    logic [2:0]           r_ovld;
    logic [2:0]           n_ovld;
    logic [1:0]           r_optr;
    logic                 r_oerr;

    logic [LW-1:0]        k_ent [9];
    logic                 in_acc;
    logic                 out_acc;
    logic [LW-1:0]        in_letter;
    logic                 group_done;
    logic [LW-1:0]        dinv;
    hc_pkg::t_kpair       kp;
    logic [3:0]           col_idx;
    hc_pkg::t_mac_op      mac_op;
    hc_pkg::t_mac_res     mac_res;
    logic                 mac_busy;

    // Key entries reduced mod 26, row-major.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                k_ent[r*3 + c] = hc_pkg::red26_5(r_key[r][5*c +: 5]);
            end
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;
    assign in_letter       = hc_pkg::red26_5(i_s_axis_tdata[LW-1:0]);
    assign group_done      = in_acc & ((r_hcnt == 2'd2) | i_s_axis_tlast);
    assign dinv            = hc_pkg::inv26(r_det);
    assign kp              = hc_pkg::adj_term(r_step);
    assign col_idx         = ({2'd0, r_row} * 4'd3) + {2'd0, r_col};

    assign o_m_axis_tvalid = r_ovld[r_optr];
    assign o_m_axis_tdata  = {3'd0, r_obuf[r_optr]};
    assign o_m_axis_tlast  = (r_optr == LAST_IX);
    assign o_m_axis_tuser  = r_oerr;
    assign out_acc         = o_m_axis_tvalid & i_m_axis_tready;

    // Operand selection for the shared unit.
    always_comb begin
        mac_op = '0;
        unique case (r_state)
            ST_ADJ: begin
                mac_op.vld   = 1'b1;
                mac_op.first = ~r_step[0];
                mac_op.sub   = r_step[0];
                mac_op.last  = r_step[0];
                mac_op.a     = k_ent[kp.ia];
                mac_op.b     = k_ent[kp.ib];
            end
            ST_DET: begin
                mac_op.vld   = 1'b1;
                mac_op.first = (r_step == 5'd0);
                mac_op.last  = (r_step == DET_LAST);
                mac_op.a     = k_ent[r_step[3:0]];
                mac_op.b     = r_adj[r_step[3:0] * 4'd3];
            end
            ST_INV: begin
                mac_op.vld   = 1'b1;
                mac_op.first = 1'b1;
                mac_op.last  = 1'b1;
                mac_op.a     = dinv;
                mac_op.b     = r_adj[r_step[3:0]];
            end
            ST_COL: begin
                mac_op.vld   = 1'b1;
                mac_op.first = (r_row == 2'd0);
                mac_op.last  = (r_row == LAST_IX);
                mac_op.a     = r_v[r_row];
                mac_op.b     = r_mode ? r_inv[col_idx] : k_ent[col_idx];
            end
            default: begin
                mac_op = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (group_done) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (!mac_busy) begin
                    if (r_mode && !r_inv_ready) begin
                        n_state = ST_ADJ;
                    end else if (r_ovld == 3'b000) begin
                        n_state = ST_COL;
                    end
                end
            end
            ST_ADJ: begin
                if (r_step == ADJ_LAST) begin
                    n_state = ST_DET;
                end
            end
            ST_DET: begin
                if (r_step == DET_LAST) begin
                    n_state = ST_WDET;
                end
            end
            ST_WDET: begin
                if (!mac_busy) begin
                    n_state = ST_INV;
                end
            end
            ST_INV: begin
                if (r_step == INV_LAST) begin
                    n_state = ST_START;
                end
            end
            ST_COL: begin
                if (r_row == LAST_IX && r_col == LAST_IX) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A returning column result marks its slot valid; an accepted word clears its own slot.
    always_comb begin
        n_ovld = r_ovld;
        if (mac_res.vld && !r_build) begin
            n_ovld[r_wr_idx[1:0]] = 1'b1;
        end
        if (out_acc) begin
            n_ovld[r_optr] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_mode      <= 1'b0;
            r_key[0]    <= '0;
            r_key[1]    <= '0;
            r_key[2]    <= '0;
            r_hcnt      <= '0;
            r_inv_ready <= 1'b0;
            r_key_ok    <= 1'b0;
            r_build     <= 1'b0;
            r_wr_idx    <= '0;
            r_ovld      <= '0;
            r_optr      <= '0;
            r_oerr      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state != n_state) ? 5'd0 : r_step + 5'd1;

            if (r_state != ST_COL) begin
                r_row <= '0;
                r_col <= '0;
            end else if (r_row == LAST_IX) begin
                r_row <= '0;
                r_col <= r_col + 2'd1;
            end else begin
                r_row <= r_row + 2'd1;
            end

            // Gather letters; a full group, or a message end with padding, hands a vector on.
            if (in_acc) begin
                if (r_hcnt == 2'd2) begin
                    r_v[0] <= r_hold[0];
                    r_v[1] <= r_hold[1];
                    r_v[2] <= in_letter;
                    r_hcnt <= '0;
                end else if (i_s_axis_tlast) begin
                    r_v[0] <= (r_hcnt == 2'd0) ? in_letter : r_hold[0];
                    r_v[1] <= (r_hcnt == 2'd0) ? hc_pkg::PAD_LETTER : in_letter;
                    r_v[2] <= hc_pkg::PAD_LETTER;
                    r_hcnt <= '0;
                end else begin
                    r_hold[r_hcnt[0]] <= in_letter;
                    r_hcnt            <= r_hcnt + 2'd1;
                end
            end

            if (r_state == ST_START && n_state == ST_ADJ) begin
                r_build  <= 1'b1;
                r_wr_idx <= '0;
            end
            if (r_state == ST_START && n_state == ST_COL) begin
                r_build  <= 1'b0;
                r_wr_idx <= '0;
                r_oerr   <= r_mode & ~r_key_ok;
            end
            if (r_state == ST_WDET && n_state == ST_INV) begin
                r_key_ok <= (dinv != '0);
            end

            // Results come back in issue order; the count tells where each belongs.
            if (mac_res.vld) begin
                r_wr_idx <= r_wr_idx + 5'd1;
                if (r_build) begin
                    if (r_wr_idx < ADJ_N) begin
                        r_adj[r_wr_idx[3:0]] <= mac_res.value;
                    end else if (r_wr_idx == DET_IDX) begin
                        r_det <= mac_res.value;
                    end else begin
                        r_inv[4'(r_wr_idx - INV_BASE)] <= mac_res.value;
                    end
                end else begin
                    r_obuf[r_wr_idx[1:0]] <= mac_res.value;
                end
            end

            r_ovld <= n_ovld;
            if (out_acc) begin
                r_optr <= (r_optr == LAST_IX) ? 2'd0 : r_optr + 2'd1;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    hc_pkg::CFG_MODE: r_mode   <= i_cfg_wdata[0];
                    hc_pkg::CFG_KEY0: r_key[0] <= i_cfg_wdata;
                    hc_pkg::CFG_KEY1: r_key[1] <= i_cfg_wdata;
                    hc_pkg::CFG_KEY2: r_key[2] <= i_cfg_wdata;
                    default:          r_mode   <= r_mode;
                endcase
            end

            // Any register write invalidates the inverse; a finished build validates it.
            if (i_cfg_we) begin
                r_inv_ready <= 1'b0;
            end else if (r_state == ST_INV && n_state == ST_START) begin
                r_inv_ready <= 1'b1;
            end
        end
    end

    hc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_res   (mac_res),
        .o_busy  (mac_busy)
    );

    `HC_ASSERT_IMPLY(a_err_zero, o_m_axis_tvalid && o_m_axis_tuser,
                     o_m_axis_tdata[4:0] == 5'd0, "error word carries a letter")
    `HC_ASSERT_IMPLY(a_col_empty, r_state == ST_COL && r_row == 2'd0 && r_col == 2'd0,
                     r_ovld == 3'b000, "group started over pending words")
    `HC_ASSERT_NEXT(a_group_start, group_done, r_state == ST_START, "full group did not start")

endmodule

### design/hc_mac.sv
// Shared two-stage multiply-accumulate unit working modulo 26.
`include "hill_cipher_3x3_mod26_top_assert.svh"

module hc_mac (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hc_pkg::t_mac_op  i_op,
    output hc_pkg::t_mac_res o_res,
    output logic             o_busy
);

    logic                            r_s1_vld;
    logic                            r_s1_first;
    logic                            r_s1_last;
    logic                            r_s1_sub;
    logic [hc_pkg::PROD_W-1:0]       r_prod;
    logic [hc_pkg::LETTER_W-1:0]     r_acc;
    logic                            r_res_vld;

    logic [hc_pkg::LETTER_W-1:0]     base;
    logic [hc_pkg::PROD_W-1:0]       term;
    logic [hc_pkg::PROD_W-1:0]       sum;

    // A first step starts a fresh sum; a subtract step adds the bias minus the product.
    always_comb begin
        base = r_s1_first ? '0 : r_acc;
        term = r_s1_sub ? hc_pkg::SUB_BIAS - r_prod : r_prod;
        sum  = {5'd0, base} + term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_op.vld;
            r_res_vld <= r_s1_vld & r_s1_last;
        end
        r_s1_first <= i_op.first;
        r_s1_last  <= i_op.last;
        r_s1_sub   <= i_op.sub;
        r_prod     <= {5'd0, i_op.a} * {5'd0, i_op.b};
        if (r_s1_vld) begin
            r_acc <= hc_pkg::mod26_10(sum);
        end
    end

    assign o_res  = '{vld: r_res_vld, value: r_acc};
    assign o_busy = r_s1_vld | r_res_vld;

    `HC_ASSERT_IMPLY(a_res_range, r_res_vld, r_acc < hc_pkg::MODULUS, "mac result not reduced")
    `HC_ASSERT_IMPLY(a_res_src, r_res_vld, $past(i_op.vld && i_op.last, 2), "mac result without op")

endmodule

### test/hill_cipher_3x3_mod26_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 mod-26 Hill cipher block with stream ports.
module hill_cipher_3x3_mod26_top_tb;
    import hc_pkg::*;

    localparam int MOD           = int'(MODULUS);
    localparam int PAD           = int'(PAD_LETTER);
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_STALL    = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_PHASE = 16;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                group_last;
        logic                key_error;
    } cipher_word_t;

    class hill_scoreboard;
        logic              mode_decrypt;
        logic [KEY_W-1:0]  key_row[3];
        int                held_letter[2];
        int                held_count;
        cipher_word_t      pending_words[$];
        int                failures;

        function new();
            mode_decrypt = 1'b0;
            key_row[0]   = '0;
            key_row[1]   = '0;
            key_row[2]   = '0;
            held_count   = 0;
            failures     = 0;
        endfunction

        function void set_register(logic [CFG_AW-1:0] idx, logic [KEY_W-1:0] value);
            case (idx)
                CFG_MODE: mode_decrypt = value[0];
                CFG_KEY0: key_row[0] = value;
                CFG_KEY1: key_row[1] = value;
                CFG_KEY2: key_row[2] = value;
                default: ;
            endcase
        endfunction

        function int mod26(int x);
            return ((x % MOD) + MOD) % MOD;
        endfunction

        function int entry(logic [KEY_W-1:0] row, int col);
            return int'((row >> (LETTER_W * col)) & 15'h1F) % MOD;
        endfunction

        // Inverse key mod 26: adjugate scaled by the inverse of the determinant.
        function bit invert_key(logic [KEY_W-1:0] r0, logic [KEY_W-1:0] r1,
                                logic [KEY_W-1:0] r2, output int inv[9]);
            logic [KEY_W-1:0] rows[3];
            int k[3][3];
            int adj[3][3];
            int det, dinv, i, j;
            rows[0] = r0;
            rows[1] = r1;
            rows[2] = r2;
            for (i = 0; i < 3; i++) begin
                for (j = 0; j < 3; j++) begin
                    k[i][j] = entry(rows[i], j);
                end
            end
            // Entry (i, j) of the adjugate is the cofactor of key entry (j, i).
            for (i = 0; i < 3; i++) begin
                for (j = 0; j < 3; j++) begin
                    adj[i][j] = mod26(k[(j+1)%3][(i+1)%3] * k[(j+2)%3][(i+2)%3]
                                    - k[(j+1)%3][(i+2)%3] * k[(j+2)%3][(i+1)%3]);
                end
            end
            det  = mod26(k[0][0] * adj[0][0] + k[0][1] * adj[1][0] + k[0][2] * adj[2][0]);
            dinv = 0;
            for (i = 1; i < MOD; i++) begin
                if (dinv == 0 && (i * det) % MOD == 1) begin
                    dinv = i;
                end
            end
            for (i = 0; i < 9; i++) begin
                inv[i] = mod26(dinv * adj[i / 3][i % 3]);
            end
            return dinv != 0;
        endfunction

        // Collects letters into groups and queues the three words each group yields.
        function void take_letter(logic [LETTER_W-1:0] raw, logic msg_end);
            int letter, acc, c, r;
            int v[3];
            int m[9];
            bit err;
            cipher_word_t w;
            letter = int'(raw) % MOD;
            if (held_count < 2) begin
                held_letter[held_count] = letter;
                held_count++;
                if (!msg_end) begin
                    return;
                end
                v[0] = held_letter[0];
                v[1] = (held_count > 1) ? held_letter[1] : PAD;
                v[2] = PAD;
            end else begin
                v[0] = held_letter[0];
                v[1] = held_letter[1];
                v[2] = letter;
            end
            held_count = 0;
            err = 1'b0;
            if (mode_decrypt) begin
                err = !invert_key(key_row[0], key_row[1], key_row[2], m);
            end else begin
                for (r = 0; r < 3; r++) begin
                    for (c = 0; c < 3; c++) begin
                        m[r * 3 + c] = entry(key_row[r], c);
                    end
                end
            end
            for (c = 0; c < 3; c++) begin
                acc = err ? 0 : (v[0] * m[c] + v[1] * m[3 + c] + v[2] * m[6 + c]) % MOD;
                w.letter     = LETTER_W'(acc);
                w.group_last = (c == 2);
                w.key_error  = err;
                pending_words.push_back(w);
            end
        endfunction

        function void check_word(logic [7:0] data, logic last, logic err);
            cipher_word_t want;
            if (pending_words.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected output word: letter %0d last %0b error %0b",
                             data, last, err);
                end
                return;
            end
            want = pending_words.pop_front();
            if (data !== {3'b000, want.letter} || last !== want.group_last
                    || err !== want.key_error) begin
                failures++;
                if (failures <= 10) begin
                    $display("word mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             want.letter, want.group_last, want.key_error, data, last, err);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata = '0;
    logic               i_s_axis_tlast = 1'b0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [7:0]         o_m_axis_tdata;
    logic               o_m_axis_tlast;
    logic               o_m_axis_tuser;
    logic               i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]  i_cfg_addr = '0;
    logic [KEY_W-1:0]   i_cfg_wdata = '0;

    hill_scoreboard board = new();

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int stalls_asked = 0;
    int stalls_served = 0;
    int stall_left = 0;
    int cycle_count = 0;

    hill_cipher_3x3_mod26_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (stalls_served != stalls_asked) begin
            stalls_served++;
            stall_left = LONG_STALL;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_word(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("** hill_cipher_3x3_mod26_top: FAILED **");
        $finish;
    end

    function automatic logic [KEY_W-1:0] key_row_of(int c0, int c1, int c2);
        return {LETTER_W'(c2), LETTER_W'(c1), LETTER_W'(c0)};
    endfunction

    function automatic logic [KEY_W-1:0] random_row();
        case ($urandom_range(9))
            0:       return '0;
            1:       return KEY_ONES;
            default: return KEY_W'($urandom);
        endcase
    endfunction

    task automatic send_letter(logic [LETTER_W-1:0] letter, logic msg_end);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, letter};
        i_s_axis_tlast  <= msg_end;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.take_letter(letter, msg_end);
    endtask

    task automatic cfg_write(logic [CFG_AW-1:0] idx, logic [KEY_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        board.set_register(idx, value);
    endtask

    task automatic load_settings(logic [KEY_W-1:0] mode_word, logic [KEY_W-1:0] k0,
                                 logic [KEY_W-1:0] k1, logic [KEY_W-1:0] k2);
        cfg_write(CFG_MODE, mode_word);
        cfg_write(CFG_KEY0, k0);
        cfg_write(CFG_KEY1, k1);
        cfg_write(CFG_KEY2, k2);
        i_cfg_we <= 1'b0;
    endtask

    // Stops offering words and waits until every queued output word has arrived.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [KEY_W-1:0] gyb_key[3];
        logic [KEY_W-1:0] rows[3];
        logic             mode;
        bit               want_invertible;
        int               scratch_inv[9];
        int               phase, n, tries, msg_left;

        gyb_key[0] = key_row_of(6, 24, 1);
        gyb_key[1] = key_row_of(13, 16, 10);
        gyb_key[2] = key_row_of(20, 17, 15);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: encrypting with an all-zero key.
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b1);
        drain();

        load_settings(KEY_W'(0), gyb_key[0], gyb_key[1], gyb_key[2]);
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd26, 1'b0);
        send_letter(5'd1, 1'b1);
        send_letter(5'd19, 1'b1);

        // Two letters held while the settings switch to decryption.
        send_letter(5'd7, 1'b0);
        send_letter(5'd4, 1'b0);
        drain();
        load_settings(KEY_ONES, gyb_key[0], gyb_key[1], gyb_key[2]);
        send_letter(5'd11, 1'b1);
        send_letter(5'd25, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd25, 1'b0);
        drain();

        // Decryption keys without an inverse: even determinant, then zero.
        load_settings(KEY_W'(1), key_row_of(2, 0, 0), key_row_of(0, 1, 0),
                      key_row_of(0, 0, 1));
        send_letter(5'd1, 1'b0);
        send_letter(5'd2, 1'b0);
        send_letter(5'd3, 1'b0);
        drain();
        load_settings(KEY_W'(1), KEY_ONES, KEY_ONES, KEY_ONES);
        send_letter(5'd31, 1'b0);
        send_letter(5'd30, 1'b1);
        drain();
        load_settings(KEY_W'(0), KEY_ONES, KEY_ONES, KEY_ONES);
        send_letter(5'd31, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd16, 1'b0);
        drain();
        // Determinant 13 has no inverse either.
        load_settings(KEY_W'(1), key_row_of(13, 0, 0), key_row_of(0, 1, 0),
                      key_row_of(0, 0, 1));
        send_letter(5'd8, 1'b1);
        drain();

        msg_left = 0;
        for (phase = 0; phase < 8; phase++) begin
            if (phase < 3) begin
                snd_idle_pct = 6;
                rcv_idle_pct = 78;
            end else if (phase < 6) begin
                snd_idle_pct = 78;
                rcv_idle_pct = 6;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            mode = (phase % 2 == 1);
            want_invertible = ($urandom_range(3) != 0);
            tries = 0;
            do begin
                rows[0] = random_row();
                rows[1] = random_row();
                rows[2] = random_row();
                tries++;
            end while (mode && want_invertible && tries < 40
                       && !board.invert_key(rows[0], rows[1], rows[2], scratch_inv));
            // Only bit 0 of the mode register matters; the rest carries noise.
            load_settings({(KEY_W-1)'($urandom), mode}, rows[0], rows[1], rows[2]);

            if (phase == 1) begin
                stalls_asked++;
            end
            // Messages may run across a phase boundary, so some groups span a settings change.
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (msg_left == 0) begin
                    msg_left = $urandom_range(1, 8);
                end
                msg_left--;
                send_letter(($urandom_range(7) == 0) ? LETTER_W'($urandom_range(31, 26))
                                                     : LETTER_W'($urandom_range(25)),
                            msg_left == 0);
            end
            drain();
        end

        if (board.pending_words.size() != 0) begin
            $display("%0d expected output words never arrived", board.pending_words.size());
            board.failures++;
        end
        if (board.failures == 0) begin
            $display("** hill_cipher_3x3_mod26_top: PASSED **");
        end else begin
            $display("** hill_cipher_3x3_mod26_top: FAILED **");
        end
        $finish;
    end

endmodule
